[rtl/ssfmt_pkg.sv]
// ============================================================================
// ssfmt_pkg
// Shared types, constants and helper functions of the seven-segment
// number formatter: request codes, queue descriptor, BCD conversion step
// and display command encoders.
// ============================================================================
package ssfmt_pkg;

    localparam int DIGIT_COUNT    = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int VALUE_W        = 28;
    localparam int MAG_W          = VALUE_W - 1;
    localparam int BCD_DIGITS     = 8;
    localparam int BCD_W          = BCD_DIGITS * 4;
    localparam int DD_STEP_BITS   = 7;
    localparam int CONV_STEPS     = 4;
    localparam int CONV_CNT_W     = $clog2(CONV_STEPS);
    localparam int PAD_W          = DD_STEP_BITS * CONV_STEPS;
    localparam int REST_W         = DD_STEP_BITS * (CONV_STEPS - 1);
    localparam int MAX_INT_DIGITS = 5;

    localparam logic [3:0] POINT_ON  = 4'h4;
    localparam logic [3:0] BLANK_VAL = 4'h0;
    localparam logic [3:0] ERR_DIGIT = 4'hF;
    localparam logic [3:0] ZERO_VAL  = 4'h0;

    localparam logic [MAG_W-1:0] MAX_MILLI [5] = '{
        MAG_W'(99999000),
        MAG_W'(9999000),
        MAG_W'(999000),
        MAG_W'(99000),
        MAG_W'(9000)
    };

    typedef enum logic [1:0] {
        REQ_RAW    = 2'd0,
        REQ_NUMBER = 2'd1,
        REQ_DOT    = 2'd2,
        REQ_ZERO   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        KIND_RAW    = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_ERROR  = 3'd2,
        KIND_DOT    = 3'd3,
        KIND_ZERO   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  raw;
        logic [1:0]  pos;
        logic [15:0] digits;
        logic        has_point;
        logic [1:0]  point;
        logic [2:0]  int_digits;
    } cmd_t;

    function automatic logic [BCD_W-1:0] dabble_bits(
        input logic [BCD_W-1:0]        bcd_in,
        input logic [DD_STEP_BITS-1:0] bits
    );
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int b = DD_STEP_BITS - 1; b >= 0; b--)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (acc[d*4 +: 4] >= 4'd5)
                begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[b]};
        end
        return acc;
    endfunction

    function automatic logic [7:0] blank_cmd(input logic [1:0] pos);
        return {4'(DIGIT_COUNT) + {2'b00, pos}, BLANK_VAL};
    endfunction

    function automatic logic [7:0] point_cmd(input logic [1:0] pos);
        return {4'(DIGIT_COUNT) + {2'b00, pos}, POINT_ON};
    endfunction

    function automatic logic [7:0] digit_cmd(input logic [1:0] pos, input logic [3:0] val);
        return {2'b00, pos, val};
    endfunction

endpackage

[rtl/seven_segment_number_formatter_core.sv]
// ============================================================================
// seven_segment_number_formatter_core
// Turns display requests into command bytes for a four-digit serial
// seven-segment display: raw bytes, numbers in thousandths with optional
// decimal point, single dot and single zero.
// ============================================================================
// Raw, dot, zero and error requests are queued on acceptance; a number first
//   passes the 4-step BCD conversion. One command byte per cycle leaves
//   while cmd_stall is low; the front takes other requests every cycle but
//   none while a number is in work or the queue is full; queue absorbs overlap.
// Reset: queue empty, no output valid, shown integer digit count set to 1.
module seven_segment_number_formatter_core
    import ssfmt_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [1:0]                req_type,
    input  logic [7:0]                raw_byte,
    input  logic signed [VALUE_W-1:0] value_milli,
    input  logic signed [2:0]         point_digits,
    input  logic [1:0]                position,
    output logic                      cmd_valid,
    input  logic                      cmd_stall,
    output logic [7:0]                cmd_byte,
    output logic                      last
);

    logic q_full;
    logic q_push;
    cmd_t q_data;
    logic q_pop;
    cmd_t q_head;
    logic q_head_valid;

    ssfmt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .raw_byte     (raw_byte),
        .value_milli  (value_milli),
        .point_digits (point_digits),
        .position     (position),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    ssfmt_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_data  (q_head),
        .head_valid (q_head_valid)
    );

    ssfmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_data  (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_byte   (cmd_byte),
        .last       (last)
    );

endmodule

[rtl/ssfmt_front.sv]
// ============================================================================
// ssfmt_front
// Request front end: accepts requests, range checks numbers, converts the
// magnitude to BCD seven bits per cycle and pushes one descriptor per
// request into the command queue.
// ============================================================================
module ssfmt_front
    import ssfmt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [1:0]                 req_type,
    input  logic [7:0]                 raw_byte,
    input  logic signed [VALUE_W-1:0]  value_milli,
    input  logic signed [2:0]          point_digits,
    input  logic [1:0]                 position,
    input  logic                       q_full,
    output logic                       q_push,
    output cmd_t                       q_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_DONE = 3'b100
    } front_state_t;

    localparam logic [CONV_CNT_W-1:0] LAST_STEP = CONV_CNT_W'(CONV_STEPS - 1);

    front_state_t            state_reg, state_next;
    logic [CONV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [REST_W-1:0]       mag_reg, mag_next;
    logic                    nopoint_reg, nopoint_next;
    logic [1:0]              point_reg, point_next;

    logic                    accept;
    logic                    no_point;
    logic [2:0]              lim_idx;
    logic [MAG_W-1:0]        mag;
    logic [PAD_W-1:0]        mag_pad;
    logic                    is_neg;
    logic                    is_over;
    logic                    is_conv;
    cmd_t                    imm_desc;
    cmd_t                    num_desc;
    logic [2:0]              int_digits;
    logic [2:0]              sel_off;
    logic [BCD_W-1:0]        bcd_shifted;

    assign req_stall = (state_reg != F_IDLE) || q_full;
    assign accept    = req_valid && !req_stall;

    assign no_point = point_digits[2];
    assign lim_idx  = no_point ? 3'd0 : {1'b0, point_digits[1:0]} + 3'd1;
    assign mag      = value_milli[MAG_W-1:0];
    assign mag_pad  = PAD_W'(mag);
    assign is_neg   = value_milli[VALUE_W-1];
    assign is_over  = mag > MAX_MILLI[lim_idx];
    assign is_conv  = (req_type == REQ_NUMBER) && !is_neg && !is_over;

    always_comb
    begin
        imm_desc            = '0;
        imm_desc.raw        = raw_byte;
        imm_desc.pos        = position;
        case (req_type)
            REQ_RAW:    imm_desc.kind = KIND_RAW;
            REQ_NUMBER: imm_desc.kind = KIND_ERROR;
            REQ_DOT:    imm_desc.kind = KIND_DOT;
            REQ_ZERO:   imm_desc.kind = KIND_ZERO;
            default:    imm_desc.kind = KIND_RAW;
        endcase
    end

    always_comb
    begin
        if (bcd_reg[31:28] != 4'd0)
        begin
            int_digits = 3'd5;
        end
        else if (bcd_reg[27:24] != 4'd0)
        begin
            int_digits = 3'd4;
        end
        else if (bcd_reg[23:20] != 4'd0)
        begin
            int_digits = 3'd3;
        end
        else if (bcd_reg[19:16] != 4'd0)
        begin
            int_digits = 3'd2;
        end
        else
        begin
            int_digits = 3'd1;
        end

        if (!nopoint_reg)
        begin
            sel_off = 3'd3 - {1'b0, point_reg};
        end
        else if (int_digits == 3'(MAX_INT_DIGITS))
        begin
            sel_off = 3'd4;
        end
        else
        begin
            sel_off = 3'd3;
        end
        bcd_shifted = bcd_reg >> {sel_off, 2'b00};

        num_desc            = '0;
        num_desc.kind       = KIND_NUMBER;
        num_desc.digits     = bcd_shifted[15:0];
        num_desc.has_point  = !nopoint_reg;
        num_desc.point      = point_reg;
        num_desc.int_digits = int_digits;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bcd_next     = bcd_reg;
        mag_next     = mag_reg;
        nopoint_next = nopoint_reg;
        point_next   = point_reg;
        q_push       = 1'b0;
        q_data       = imm_desc;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (is_conv)
                    begin
                        state_next   = F_CONV;
                        cnt_next     = CONV_CNT_W'(1);
                        bcd_next     = dabble_bits('0, mag_pad[PAD_W-1 -: DD_STEP_BITS]);
                        mag_next     = mag_pad[REST_W-1:0];
                        nopoint_next = no_point;
                        point_next   = point_digits[1:0];
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
            end
            F_CONV:
            begin
                bcd_next = dabble_bits(bcd_reg, mag_reg[REST_W-1 -: DD_STEP_BITS]);
                mag_next = mag_reg << DD_STEP_BITS;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                q_data = num_desc;
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg     <= bcd_next;
        mag_reg     <= mag_next;
        nopoint_reg <= nopoint_next;
        point_reg   <= point_next;
    end

    a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DONE && !q_full) |=> (state_reg == F_IDLE))
        else $error("front did not return to idle after pushing a number");

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CONV) |-> (cnt_reg != '0))
        else $error("conversion step count out of sequence");

endmodule

[rtl/ssfmt_queue.sv]
// ============================================================================
// ssfmt_queue
// Small descriptor queue between the request front end and the command
// back end.
// ============================================================================
module ssfmt_queue
    import ssfmt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head_data,
    output logic head_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

[rtl/ssfmt_back.sv]
// ============================================================================
// ssfmt_back
// Command back end: walks the descriptor at the queue head one command
// byte per cycle while cmd_stall is low, applies leading-digit blanking
// and holds the digit count of the last number shown.
// ============================================================================
module ssfmt_back
    import ssfmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head_data,
    input  logic       head_valid,
    output logic       pop,
    output logic       cmd_valid,
    input  logic       cmd_stall,
    output logic [7:0] cmd_byte,
    output logic       last
);

    localparam logic [2:0] LAST_DIGIT = 3'(DIGIT_COUNT - 1);
    localparam logic [2:0] POINT_SLOT = 3'(DIGIT_COUNT);

    logic [2:0] idx_reg, idx_next;
    logic [2:0] shown_reg, shown_next;
    logic       cmd_valid_reg, cmd_valid_next;
    logic [7:0] cmd_byte_reg, cmd_byte_next;
    logic       last_reg, last_next;

    logic       load;
    logic [1:0] pos;
    logic       at_point;
    logic [2:0] eff_shown;
    logic [1:0] base;
    logic       blank;
    logic [3:0] digit;
    logic [7:0] gen_byte;
    logic       gen_last;

    assign pos      = idx_reg[1:0];
    assign at_point = (idx_reg == POINT_SLOT);
    assign digit    = head_data.digits[pos*4 +: 4];

    always_comb
    begin
        eff_shown = (head_data.kind == KIND_NUMBER) ? head_data.int_digits : shown_reg;
        base      = (head_data.kind == KIND_NUMBER && head_data.has_point) ?
                    head_data.point : 2'd0;
        blank     = (idx_reg != 3'd0) &&
                    ({1'b0, idx_reg} >= ({2'b00, base} + {1'b0, eff_shown}));

        case (head_data.kind)
            KIND_RAW:
            begin
                gen_byte = head_data.raw;
                gen_last = 1'b1;
            end
            KIND_NUMBER:
            begin
                if (at_point)
                begin
                    gen_byte = point_cmd(head_data.point);
                end
                else if (blank)
                begin
                    gen_byte = blank_cmd(pos);
                end
                else
                begin
                    gen_byte = digit_cmd(pos, digit);
                end
                gen_last = head_data.has_point ? at_point : (idx_reg == LAST_DIGIT);
            end
            KIND_ERROR:
            begin
                gen_byte = blank ? blank_cmd(pos) : digit_cmd(pos, ERR_DIGIT);
                gen_last = (idx_reg == LAST_DIGIT);
            end
            KIND_DOT:
            begin
                gen_byte = at_point ? point_cmd(head_data.pos) : blank_cmd(pos);
                gen_last = at_point;
            end
            KIND_ZERO:
            begin
                gen_byte = at_point ? digit_cmd(head_data.pos, ZERO_VAL) : blank_cmd(pos);
                gen_last = at_point;
            end
            default:
            begin
                gen_byte = blank_cmd(pos);
                gen_last = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!cmd_valid_reg || !cmd_stall);
    assign pop  = load && gen_last;

    always_comb
    begin
        idx_next       = idx_reg;
        shown_next     = shown_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_byte_next  = cmd_byte_reg;
        last_next      = last_reg;
        if (load)
        begin
            cmd_valid_next = 1'b1;
            cmd_byte_next  = gen_byte;
            last_next      = gen_last;
            if (gen_last)
            begin
                idx_next = 3'd0;
                if (head_data.kind == KIND_NUMBER)
                begin
                    shown_next = head_data.int_digits;
                end
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (!cmd_stall)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            shown_reg     <= 3'd1;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            shown_reg     <= shown_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_byte_reg <= cmd_byte_next;
        last_reg     <= last_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_byte  = cmd_byte_reg;
    assign last      = last_reg;

    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        (shown_reg != 3'd0) && (shown_reg <= 3'(MAX_INT_DIGITS)))
        else $error("shown digit count out of range");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= POINT_SLOT)
        else $error("command index past the point slot");

endmodule
